### src/pli_pkg.sv
// Shared constants and types for the piecewise linear interpolator.
package pli_pkg;

    localparam int SEGMENTS_DEFAULT = 16;
    localparam int SEG_INDEX_W      = 4;
    localparam int RATE_W           = 16;
    localparam int VALUE_W          = 32;
    localparam int COUNT_W          = 5;

    localparam int CMD_DEPTH        = 2;
    localparam int CMD_PTR_W        = $clog2(CMD_DEPTH);

    localparam int PROD_W           = RATE_W + VALUE_W;
    localparam int DIV_BITS         = 2;
    localparam int DIV_STEPS        = PROD_W / DIV_BITS;
    localparam int DIV_CNT_W        = $clog2(DIV_STEPS + 1);

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_SKIP  = 2'd1,
        CMD_QUERY = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                   kind;
        logic [SEG_INDEX_W-1:0]      seg_index;
        logic [RATE_W-1:0]           rate_start;
        logic [RATE_W-1:0]           rate_end;
        logic signed [VALUE_W-1:0]   value_start;
        logic signed [VALUE_W-1:0]   value_end;
        logic [RATE_W-1:0]           query_rate;
    } cmd_t;

endpackage

### src/pli_front.sv
// Input side: count register, word classification and command queue.
module pli_front #(
    parameter int SEGMENTS = pli_pkg::SEGMENTS_DEFAULT,
    localparam int CNT_W = $clog2(SEGMENTS + 1)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic                                 req_type,
    input  logic [pli_pkg::SEG_INDEX_W-1:0]      seg_index,
    input  logic [pli_pkg::RATE_W-1:0]           rate_start,
    input  logic [pli_pkg::RATE_W-1:0]           rate_end,
    input  logic signed [pli_pkg::VALUE_W-1:0]   value_start,
    input  logic signed [pli_pkg::VALUE_W-1:0]   value_end,
    input  logic [pli_pkg::RATE_W-1:0]           query_rate,
    input  logic                                 cfg_we,
    input  logic [pli_pkg::COUNT_W-1:0]          cfg_wdata,
    output logic                                 cmd_valid,
    output pli_pkg::cmd_t                        cmd,
    input  logic                                 cmd_pop,
    output logic [CNT_W-1:0]                     seg_count
);
    import pli_pkg::*;

    logic [COUNT_W-1:0]   seg_in_use_reg;
    cmd_t                 fifo_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_PTR_W:0]   fill_reg;
    logic [CMD_PTR_W-1:0] wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_next;
    logic [CMD_PTR_W:0]   fill_next;
    cmd_t                 push_word;
    logic                 do_push;
    logic                 do_pop;

    assign full      = (fill_reg == (CMD_PTR_W + 1)'(CMD_DEPTH));
    assign cmd_valid = (fill_reg != '0);
    assign cmd       = fifo_mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    always_comb
    begin
        push_word.seg_index   = seg_index;
        push_word.rate_start  = rate_start;
        push_word.rate_end    = rate_end;
        push_word.value_start = value_start;
        push_word.value_end   = value_end;
        push_word.query_rate  = query_rate;
        if (req_type)
        begin
            push_word.kind = CMD_QUERY;
        end
        else if (32'(seg_index) < SEGMENTS)
        begin
            push_word.kind = CMD_LOAD;
        end
        else
        begin
            push_word.kind = CMD_SKIP;
        end
    end

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_comb
    begin
        if (32'(seg_in_use_reg) > SEGMENTS)
        begin
            seg_count = CNT_W'(SEGMENTS);
        end
        else
        begin
            seg_count = CNT_W'(seg_in_use_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_in_use_reg <= '0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fill_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                seg_in_use_reg <= cfg_wdata;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            fifo_mem[wr_ptr_reg] <= push_word;
        end
    end

endmodule

### src/pli_div.sv
// Restoring divider, two quotient bits per cycle.
module pli_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pli_pkg::PROD_W-1:0]  dividend,
    input  logic [pli_pkg::RATE_W-1:0]  divisor,
    output logic                        done,
    output logic [pli_pkg::PROD_W-1:0]  quotient
);
    import pli_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [PROD_W-1:0]    dvd_reg;
    logic [RATE_W-1:0]    rem_reg;
    logic [RATE_W-1:0]    divisor_reg;
    logic [PROD_W-1:0]    dvd_next;
    logic [RATE_W-1:0]    rem_next;
    logic [RATE_W:0]      trial;

    assign done     = done_reg;
    assign quotient = dvd_reg;

    always_comb
    begin
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        trial    = '0;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            trial    = {rem_next, dvd_next[PROD_W-1]};
            dvd_next = {dvd_next[PROD_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor_reg})
            begin
                trial       = trial - {1'b0, divisor_reg};
                dvd_next[0] = 1'b1;
            end
            rem_next = trial[RATE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg     <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

endmodule

### src/pli_back.sv
// Execution side: segment table, scan, interpolation and result register.
module pli_back #(
    parameter int SEGMENTS = pli_pkg::SEGMENTS_DEFAULT,
    localparam int CNT_W = $clog2(SEGMENTS + 1),
    localparam int IDX_W = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cmd_valid,
    input  pli_pkg::cmd_t                        cmd,
    output logic                                 cmd_pop,
    input  logic [CNT_W-1:0]                     seg_count,
    output logic                                 empty,
    input  logic                                 pop,
    output logic                                 found,
    output logic signed [pli_pkg::VALUE_W-1:0]   value
);
    import pli_pkg::*;

    typedef struct packed {
        logic [RATE_W-1:0]  rate_start;
        logic [RATE_W-1:0]  rate_end;
        logic [VALUE_W-1:0] value_start;
        logic [VALUE_W-1:0] value_end;
    } seg_t;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_PREP = 6'b000100,
        S_MUL  = 6'b001000,
        S_DIV  = 6'b010000,
        S_FIN  = 6'b100000
    } state_t;

    seg_t               seg_mem [SEGMENTS];
    seg_t               rd_data_reg;
    seg_t               seg_reg;
    seg_t               wr_data;
    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   issue_reg;
    logic               pend_reg;
    logic [RATE_W-1:0]  rate_reg;
    logic               hit_reg;
    logic               neg_reg;
    logic [VALUE_W-1:0] mag_reg;
    logic [RATE_W-1:0]  off_reg;
    logic [RATE_W-1:0]  span_reg;
    logic               out_valid_reg;
    logic               found_reg;
    logic [VALUE_W-1:0] value_reg;

    logic               out_free;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic               mem_we;
    logic               issue_more;
    logic               seg_hit;
    logic [VALUE_W:0]   diff;
    logic               res_load;
    logic               res_found;
    logic [VALUE_W-1:0] res_value;
    logic               div_start;
    logic               div_done;
    logic [PROD_W-1:0]  div_dvd;
    logic [PROD_W-1:0]  div_quot;
    logic [VALUE_W-1:0] q_low;

    assign empty      = !out_valid_reg;
    assign found      = found_reg;
    assign value      = value_reg;
    assign out_free   = !out_valid_reg || pop;
    assign rd_addr    = issue_reg[IDX_W-1:0];
    assign wr_addr    = IDX_W'(cmd.seg_index);
    assign issue_more = (issue_reg < seg_count);
    assign seg_hit    = (rd_data_reg.rate_start <= rate_reg) && (rate_reg < rd_data_reg.rate_end);
    assign diff       = {seg_reg.value_end[VALUE_W-1], seg_reg.value_end}
                      - {seg_reg.value_start[VALUE_W-1], seg_reg.value_start};
    assign q_low      = div_quot[VALUE_W-1:0];
    assign div_start  = (state_reg == S_MUL);
    assign div_dvd    = PROD_W'(mag_reg) * PROD_W'(off_reg);

    always_comb
    begin
        wr_data.rate_start  = cmd.rate_start;
        wr_data.rate_end    = cmd.rate_end;
        wr_data.value_start = cmd.value_start;
        wr_data.value_end   = cmd.value_end;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_pop    = 1'b0;
        mem_we     = 1'b0;
        res_load   = 1'b0;
        res_found  = 1'b0;
        res_value  = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.kind)
                        CMD_QUERY:
                        begin
                            cmd_pop    = 1'b1;
                            state_next = S_SCAN;
                        end
                        CMD_LOAD:
                        begin
                            if (out_free)
                            begin
                                cmd_pop  = 1'b1;
                                mem_we   = 1'b1;
                                res_load = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (out_free)
                            begin
                                cmd_pop  = 1'b1;
                                res_load = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (pend_reg && seg_hit)
                begin
                    state_next = S_PREP;
                end
                else if (!pend_reg && !issue_more)
                begin
                    state_next = S_FIN;
                end
            end
            S_PREP:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    res_found  = hit_reg;
                    res_value  = !hit_reg ? '0 :
                                 (neg_reg ? seg_reg.value_start - q_low
                                          : seg_reg.value_start + q_low);
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE)
            begin
                issue_reg <= '0;
                pend_reg  <= 1'b0;
                hit_reg   <= 1'b0;
            end
            else if (state_reg == S_SCAN)
            begin
                pend_reg <= issue_more;
                if (issue_more)
                begin
                    issue_reg <= issue_reg + 1'b1;
                end
            end
            else if (state_reg == S_PREP)
            begin
                hit_reg <= 1'b1;
            end
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE)
        begin
            rate_reg <= cmd.query_rate;
        end
        if (state_reg == S_SCAN)
        begin
            seg_reg <= rd_data_reg;
        end
        if (state_reg == S_PREP)
        begin
            neg_reg  <= diff[VALUE_W];
            mag_reg  <= diff[VALUE_W] ? VALUE_W'(-diff) : diff[VALUE_W-1:0];
            off_reg  <= rate_reg - seg_reg.rate_start;
            span_reg <= seg_reg.rate_end - seg_reg.rate_start;
        end
        if (res_load)
        begin
            found_reg <= res_found;
            value_reg <= res_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            seg_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= seg_mem[rd_addr];
    end

    pli_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (span_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide state");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (state_reg == S_IDLE) && cmd_valid)
        else $error("command taken while busy");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (!out_valid_reg || pop))
        else $error("result register overwritten");

    a_span_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (span_reg != '0))
        else $error("matched segment with empty range");

endmodule

### src/piecewise_linear_interpolator.sv
// Top level of the piecewise linear interpolator.
//
// Input channel: an input word is taken when push is high and full is low.
// req_type 0 loads one segment into slot seg_index; a slot beyond the table
// is dropped. req_type 1 looks up query_rate in the first cfg segments.
// Result channel: while empty is low the oldest result is on found/value;
// pop takes it. Every input word gives exactly one result word; a load and
// a miss return found 0, value 0.
// cfg_we writes the count of searched segments; write it while idle only.
// A load is written by the execution stage while it is idle; its result
// shows in the cycle after it is taken. A query scans the segment table
// one entry a cycle through its single read port; on a hit, a 48-bit by
// 16-bit divide then runs at 2 quotient bits per step.
// Queries run one at a time; a two-word command queue keeps push open.
// Reset clears the queue, the result register and the count; the segment
// table holds no reset and must be loaded before it is searched.
// A stalled result register holds the execution stage, then the queue, and
// full rises once the queue is full.
module piecewise_linear_interpolator #(
    parameter int SEGMENTS = pli_pkg::SEGMENTS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic                                 req_type,
    input  logic [pli_pkg::SEG_INDEX_W-1:0]      seg_index,
    input  logic [pli_pkg::RATE_W-1:0]           rate_start,
    input  logic [pli_pkg::RATE_W-1:0]           rate_end,
    input  logic signed [pli_pkg::VALUE_W-1:0]   value_start,
    input  logic signed [pli_pkg::VALUE_W-1:0]   value_end,
    input  logic [pli_pkg::RATE_W-1:0]           query_rate,
    input  logic                                 cfg_we,
    input  logic [pli_pkg::COUNT_W-1:0]          cfg_wdata,
    output logic                                 empty,
    input  logic                                 pop,
    output logic                                 found,
    output logic signed [pli_pkg::VALUE_W-1:0]   value
);
    import pli_pkg::*;

    localparam int CNT_W = $clog2(SEGMENTS + 1);

    logic             cmd_valid;
    cmd_t             cmd;
    logic             cmd_pop;
    logic [CNT_W-1:0] seg_count;

    pli_front #(
        .SEGMENTS (SEGMENTS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .req_type    (req_type),
        .seg_index   (seg_index),
        .rate_start  (rate_start),
        .rate_end    (rate_end),
        .value_start (value_start),
        .value_end   (value_end),
        .query_rate  (query_rate),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop),
        .seg_count   (seg_count)
    );

    pli_back #(
        .SEGMENTS (SEGMENTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .seg_count (seg_count),
        .empty     (empty),
        .pop       (pop),
        .found     (found),
        .value     (value)
    );

endmodule
